### design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge, held off while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### design/wsp_pkg.sv
`default_nettype none
package wsp_pkg;
    // Fixed point format of coefficients and coordinates.
    localparam int FRAC_BITS = 16;
    localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

    // Widths of the clip values and of the pixel mapping.
    localparam int CLIP_W = 52;
    localparam int NUM_W = 68;
    localparam int Q_BITS = 24;
    localparam int CMP_W = NUM_W + 8;
    localparam int DIV_LAT = Q_BITS + 2;
    localparam int FRONT_LAT = 4;
    localparam int LAT = FRONT_LAT + DIV_LAT;

    // Output coding.
    localparam logic signed [23:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [23:0] OUT_MIN = -24'sd8388608;
    localparam logic signed [23:0] NO_POINT = -24'sd1000;

    // Register indexes.
    localparam logic [7:0] REG_ROW_X_A = 8'd0;
    localparam logic [7:0] REG_ROW_X_B = 8'd1;
    localparam logic [7:0] REG_ROW_Y_A = 8'd2;
    localparam logic [7:0] REG_ROW_Y_B = 8'd3;
    localparam logic [7:0] REG_ROW_W_A = 8'd4;
    localparam logic [7:0] REG_ROW_W_B = 8'd5;
    localparam logic [7:0] REG_VIEW_W = 8'd6;
    localparam logic [7:0] REG_VIEW_H = 8'd7;

    // One operand set handed to the pixel divider.
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [CLIP_W-1:0] den;
        logic              neg;
        logic              zero;
    } t_div_op;
endpackage
`default_nettype wire

### design/wsp_div.sv
`default_nettype none
`include "assert_macros.svh"
// Pipelined restoring divider: one quotient bit per stage, saturated to 24 bits.
module wsp_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_ce,
    input  wire wsp_pkg::t_div_op i_op,
    output logic [23:0]           o_pix
);
    localparam int QB = wsp_pkg::Q_BITS;
    localparam int NW = wsp_pkg::NUM_W;
    localparam int CW = wsp_pkg::CMP_W;

    logic [NW-1:0]                r_rem [0:QB-1];
    logic [wsp_pkg::CLIP_W-1:0]   r_den [0:QB];
    logic [QB-1:0]                r_q   [0:QB];
    logic                         r_neg [0:QB];
    logic                         r_zero[0:QB];
    logic                         r_sat [0:QB];
    logic [23:0]                  r_pix;
    logic [23:0]                  n_pix;

    // Setup stage: a quotient of 2^24 or more saturates.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= i_op.num;
            r_den[0]  <= i_op.den;
            r_q[0]    <= '0;
            r_neg[0]  <= i_op.neg;
            r_zero[0] <= i_op.zero;
            r_sat[0]  <= CW'(i_op.num) >= (CW'(i_op.den) << QB);
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j <= QB; j++) begin : g_stage
        localparam int BIT = QB - j;
        logic [CW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = CW'(r_den[j-1]) << BIT;
        assign w_ge = CW'(r_rem[j-1]) >= w_sh;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_den[j]  <= r_den[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_zero[j] <= r_zero[j-1];
                r_sat[j]  <= r_sat[j-1];
                r_q[j]    <= r_q[j-1] | (QB'(w_ge) << BIT);
            end
        end
        if (j < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[j] <= w_ge ? NW'(CW'(r_rem[j-1]) - w_sh) : r_rem[j-1];
                end
            end
        end
    end

    // Sign, saturation and the marker for a zero w.
    always_comb begin
        if (r_zero[QB]) begin
            n_pix = wsp_pkg::NO_POINT;
        end else if (r_sat[QB] || r_q[QB][QB-1]) begin
            n_pix = r_neg[QB] ? wsp_pkg::OUT_MIN : wsp_pkg::OUT_MAX;
        end else if (r_neg[QB]) begin
            n_pix = 24'(-r_q[QB]);
        end else begin
            n_pix = r_q[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

    `ASSERT_CLK(a_rem_below_shift, i_clk, i_rst_n,
        r_sat[0] || (CW'(r_rem[0]) < (CW'(r_den[0]) << QB)) || r_den[0] == '0)
    `ASSERT_CLK(a_sat_hold, i_clk, i_rst_n, !i_ce |=> $stable(r_sat[QB]))
    `ASSERT_CLK(a_zero_marker, i_clk, i_rst_n,
        (i_ce && r_zero[QB]) |=> r_pix == wsp_pkg::NO_POINT)
endmodule
`default_nettype wire

### design/world_to_screen_projection_unit.sv
`default_nettype none
`include "assert_macros.svh"
// World to screen projection.
// The slave stream takes one world point per word (x, y, z, signed Q16.16).
// The point is multiplied by the loaded x, y and w rows of the combined
// projection and view matrix and mapped to a pixel position on the master
// stream, with tuser set when clip w was exactly zero (pixel -1000, -1000).
// Rows and the view size are written over the configuration channel; the user
// must do so only while the pipe is empty (the block does not enforce this).
// The channel is always ready and unknown indexes are dropped. Four stages of
// multiply, sum, clip offset and scale feed the divider with one setup stage,
// one stage per quotient bit (24) and an output register. One point is
// accepted every cycle unless the master side stalls. The whole pipe advances
// together: when the master side stalls with a word waiting, every stage
// holds and s_axis_tready drops until it is taken. Reset (synchronous, active
// low) restores the default matrix, clears the view size and empties the pipe.
module world_to_screen_projection_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // screen_x[23:0], screen_y[47:24]
    output logic             m_axis_tuser,  // w_was_zero[0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    localparam int F  = wsp_pkg::FRAC_BITS;
    localparam int CL = wsp_pkg::CLIP_W;
    localparam int NW = wsp_pkg::NUM_W;

    logic [63:0] r_row [0:5];
    logic [15:0] r_view_w;
    logic [15:0] r_view_h;
    logic        w_ce;
    logic [wsp_pkg::LAT-1:0] r_vld;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= wsp_pkg::ONE_FX;
            r_row[1] <= '0;
            r_row[2] <= wsp_pkg::ONE_FX << 32;
            r_row[3] <= '0;
            r_row[4] <= '0;
            r_row[5] <= wsp_pkg::ONE_FX << 32;
            r_view_w <= '0;
            r_view_h <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wsp_pkg::REG_ROW_X_A: r_row[0] <= i_cfg_data;
                wsp_pkg::REG_ROW_X_B: r_row[1] <= i_cfg_data;
                wsp_pkg::REG_ROW_Y_A: r_row[2] <= i_cfg_data;
                wsp_pkg::REG_ROW_Y_B: r_row[3] <= i_cfg_data;
                wsp_pkg::REG_ROW_W_A: r_row[4] <= i_cfg_data;
                wsp_pkg::REG_ROW_W_B: r_row[5] <= i_cfg_data;
                wsp_pkg::REG_VIEW_W:  r_view_w <= i_cfg_data[15:0];
                wsp_pkg::REG_VIEW_H:  r_view_h <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipe enable and valid bits.
    assign w_ce = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_ce;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[wsp_pkg::LAT-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[wsp_pkg::LAT-1];

    // Stage 1: nine coefficient by coordinate products.
    logic signed [63:0] r_prod [0:2][0:2];
    logic signed [31:0] w_pos  [0:2];
    assign w_pos[0] = s_axis_tdata[31:0];
    assign w_pos[1] = s_axis_tdata[63:32];
    assign w_pos[2] = s_axis_tdata[95:64];
    for (genvar r = 0; r < 3; r++) begin : g_mul
        logic signed [31:0] w_c0, w_c1, w_c2;
        assign w_c0 = r_row[2*r][31:0];
        assign w_c1 = r_row[2*r][63:32];
        assign w_c2 = r_row[2*r+1][31:0];
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_prod[r][0] <= w_c0 * w_pos[0];
                r_prod[r][1] <= w_c1 * w_pos[1];
                r_prod[r][2] <= w_c2 * w_pos[2];
            end
        end
    end

    // Stage 2: floor each product to Q.16 and sum with the constant term.
    logic signed [CL-1:0] r_clip [0:2];
    for (genvar r = 0; r < 3; r++) begin : g_sum
        logic signed [31:0] w_c3;
        assign w_c3 = r_row[2*r+1][63:32];
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_clip[r] <= CL'(r_prod[r][0] >>> F) + CL'(r_prod[r][1] >>> F)
                           + CL'(r_prod[r][2] >>> F) + CL'(w_c3);
            end
        end
    end

    // Stage 3: |w| and the offset numerators.
    logic [CL-1:0]        r_mag;
    logic                 r_wz3;
    logic signed [CL-1:0] r_num_x;
    logic signed [CL-1:0] r_num_y;
    logic [CL-1:0]        w_mag;
    assign w_mag = r_clip[2][CL-1] ? CL'(-r_clip[2]) : r_clip[2];
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_mag   <= w_mag;
            r_wz3   <= r_clip[2] == '0;
            r_num_x <= r_clip[0] + signed'(w_mag);
            r_num_y <= signed'(w_mag) - r_clip[1];
        end
    end

    // Stage 4: scale the numerator magnitudes by the view size.
    wsp_pkg::t_div_op r_op_x;
    wsp_pkg::t_div_op r_op_y;
    logic [CL-1:0] w_abs_x;
    logic [CL-1:0] w_abs_y;
    assign w_abs_x = r_num_x[CL-1] ? CL'(-r_num_x) : r_num_x;
    assign w_abs_y = r_num_y[CL-1] ? CL'(-r_num_y) : r_num_y;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_op_x.num  <= NW'(w_abs_x) * NW'(r_view_w);
            r_op_x.den  <= CL'(r_mag << 1);
            r_op_x.neg  <= r_num_x[CL-1];
            r_op_x.zero <= r_wz3;
            r_op_y.num  <= NW'(w_abs_y) * NW'(r_view_h);
            r_op_y.den  <= CL'(r_mag << 1);
            r_op_y.neg  <= r_num_y[CL-1];
            r_op_y.zero <= r_wz3;
        end
    end

    // Divider pipes, one per axis.
    logic [23:0] w_pix_x;
    logic [23:0] w_pix_y;
    logic        r_wz [0:wsp_pkg::DIV_LAT-1];

    wsp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_op    (r_op_x),
        .o_pix   (w_pix_x)
    );

    wsp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_op    (r_op_y),
        .o_pix   (w_pix_y)
    );

    // Zero w flag travels alongside the divider.
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_wz[0] <= r_op_x.zero;
            for (int k = 1; k < wsp_pkg::DIV_LAT; k++) begin
                r_wz[k] <= r_wz[k-1];
            end
        end
    end

    assign m_axis_tdata = {w_pix_y, w_pix_x};
    assign m_axis_tuser = r_wz[wsp_pkg::DIV_LAT-1];

    `ASSERT_CLK(a_marker, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser) |->
        (w_pix_x == wsp_pkg::NO_POINT && w_pix_y == wsp_pkg::NO_POINT))
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, !w_ce |=> $stable(r_vld))
    `ASSERT_CLK(a_ready, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
endmodule
`default_nettype wire
